// ----- design/lpfr_pkg.sv -----
package lpfr_pkg;

   localparam int COLUMNS = 128;
   localparam int ROWS    = 64;
   localparam int PAGES   = 8;
   localparam int PAGE_W  = 3;
   localparam int DEPTH   = PAGES * COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int BC_W    = $clog2(COLUMNS + 3);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic       FLIPPED_RST       = 1'b1;
   localparam logic       DIRTY_ONLY_RST    = 1'b0;
   localparam logic [2:0] PAGE_ROTATE_RST   = 3'd4;
   localparam logic [7:0] PAGE_CMD_BASE_RST = 8'd176;
   localparam logic [7:0] COL_LOW_CMD_RST   = 8'd0;
   localparam logic [7:0] COL_HIGH_CMD_RST  = 8'd16;
   localparam logic [7:0] FLIP_COL_OFFSET   = 8'd4;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_CLEAR = 2'd1,
      OP_START = 2'd2,
      OP_STEP  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FLIPPED       = 3'd0,
      REG_DIRTY_ONLY    = 3'd1,
      REG_PAGE_ROTATE   = 3'd2,
      REG_PAGE_CMD_BASE = 3'd3,
      REG_COL_LOW_CMD   = 3'd4,
      REG_COL_HIGH_CMD  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic       flipped;
      logic       dirty_only;
      logic [2:0] page_rotate;
      logic [7:0] page_cmd_base;
      logic [7:0] col_low_cmd;
      logic [7:0] col_high_cmd;
   } cfg_type;

endpackage

// ----- design/lpfr_ram.sv -----
module lpfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

// ----- design/lpfr_csr.sv -----
module lpfr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [lpfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lpfr_pkg::CSR_DATA_W-1:0]    csr_data,
   output lpfr_pkg::cfg_type                  cfg
);

   import lpfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_FLIPPED:       cfg_in.flipped       = csr_data[0];
            REG_DIRTY_ONLY:    cfg_in.dirty_only    = csr_data[0];
            REG_PAGE_ROTATE:   cfg_in.page_rotate   = csr_data[2:0];
            REG_PAGE_CMD_BASE: cfg_in.page_cmd_base = csr_data;
            REG_COL_LOW_CMD:   cfg_in.col_low_cmd   = csr_data;
            REG_COL_HIGH_CMD:  cfg_in.col_high_cmd  = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flipped       <= FLIPPED_RST;
         cfg_ff.dirty_only    <= DIRTY_ONLY_RST;
         cfg_ff.page_rotate   <= PAGE_ROTATE_RST;
         cfg_ff.page_cmd_base <= PAGE_CMD_BASE_RST;
         cfg_ff.col_low_cmd   <= COL_LOW_CMD_RST;
         cfg_ff.col_high_cmd  <= COL_HIGH_CMD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/lcd_page_framebuffer_refresh.sv -----
// Page-organized monochrome framebuffer with a panel refresh sequencer. The store is
// one single-port RAM of eight pages by COLUMNS bytes; every access goes through its one
// port, so a pixel write reads the byte and then writes it back, and a refresh step
// that yields a byte reads the RAM and then loads the output register. A start takes
// effect as it is accepted; a clear then sweeps the RAM one entry a cycle over all
// 8*COLUMNS entries (1024 at 128 columns), and the same sweep runs after reset, with no
// item accepted meanwhile. CSR writes are taken at any time. The output register lets
// a pixel write, clear or start be accepted while a byte waits for its transfer.
module lcd_page_framebuffer_refresh (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_column,
   input  logic [7:0]                      req_row,
   input  logic                            req_colour,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_byte_out,
   output logic                            rsp_is_data,
   output logic                            rsp_last_of_refresh,
   input  logic                            csr_write_enable,
   input  logic [lpfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpfr_pkg::CSR_DATA_W-1:0] csr_data
);

   import lpfr_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_STEP_WAIT
   } state_type;

   function automatic logic [PAGE_W:0] next_page(logic [PAGE_W:0] from,
                                                 logic [PAGES-1:0] mask,
                                                 logic only);
      logic [PAGE_W:0] res;
      res = (PAGE_W+1)'(PAGES);
      for (int i = PAGES - 1; i >= 0; i--) begin
         if ((PAGE_W+1)'(i) >= from && (!only || mask[i])) begin
            res = (PAGE_W+1)'(i);
         end
      end
      return res;
   endfunction

   cfg_type cfg;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              busy_ff, busy_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [BC_W-1:0]   byte_ff, byte_in;
   logic [PAGES-1:0]  dirty_ff, dirty_in;
   logic [ADDR_W-1:0] pix_addr_ff, pix_addr_in;
   logic [7:0]        pix_bit_ff, pix_bit_in;
   logic              pix_colour_ff, pix_colour_in;
   logic [7:0]        pend_cmd_ff, pend_cmd_in;
   logic              pend_data_ff, pend_data_in;
   logic              pend_last_ff, pend_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_is_data_ff, rsp_is_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   op_type            op;
   logic              accept;
   logic              pix_in_range;
   logic [7:0]        row0;
   logic [PAGE_W-1:0] pix_page;
   logic [ADDR_W-1:0] pix_addr;
   logic [BC_W-1:0]   data_col;
   logic [ADDR_W-1:0] step_addr;
   logic [PAGE_W:0]   start_page;
   logic [PAGE_W:0]   follow_page;

   lpfr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   lpfr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   (ram_wdata),
      .read_data    (ram_rdata)
   );

   assign op        = op_type'(req_operation);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready || op != OP_STEP);
   assign accept    = req_valid && req_ready;

   assign row0         = req_row - 8'd1;
   assign pix_page     = row0[5:3];
   assign pix_in_range = ({1'b0, req_column} < 9'(COLUMNS)) && (req_row != 8'd0)
                         && (req_row <= 8'(ROWS));
   assign pix_addr     = ADDR_W'(pix_page) * ADDR_W'(COLUMNS) + ADDR_W'(req_column);

   always_comb begin
      data_col = byte_ff - BC_W'(3);
      if (data_col >= BC_W'(COLUMNS)) begin
         data_col = BC_W'(COLUMNS - 1);
      end
   end

   assign step_addr   = ADDR_W'(page_ff) * ADDR_W'(COLUMNS) + ADDR_W'(data_col);
   assign start_page  = next_page('0, dirty_ff, cfg.dirty_only);
   assign follow_page = next_page({1'b0, page_ff} + (PAGE_W+1)'(1), dirty_ff, cfg.dirty_only);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      busy_in        = busy_ff;
      page_in        = page_ff;
      byte_in        = byte_ff;
      dirty_in       = dirty_ff;
      pix_addr_in    = pix_addr_ff;
      pix_bit_in     = pix_bit_ff;
      pix_colour_in  = pix_colour_ff;
      pend_cmd_in    = pend_cmd_ff;
      pend_data_in   = pend_data_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_addr       = step_addr;
      ram_wdata      = 8'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (op == OP_PIXEL) begin
               ram_addr = pix_addr;
            end
            if (accept) begin
               unique case (op)
                  OP_PIXEL: begin
                     if (pix_in_range) begin
                        dirty_in[pix_page] = 1'b1;
                        pix_addr_in        = pix_addr;
                        pix_bit_in         = 8'd1 << row0[2:0];
                        pix_colour_in      = req_colour;
                        state_in           = ST_RMW;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  OP_START: begin
                     byte_in = '0;
                     if (start_page[PAGE_W]) begin
                        busy_in  = 1'b0;
                        page_in  = '0;
                        dirty_in = '0;
                     end else begin
                        busy_in = 1'b1;
                        page_in = start_page[PAGE_W-1:0];
                     end
                  end
                  OP_STEP: begin
                     if (busy_ff) begin
                        state_in     = ST_STEP_WAIT;
                        pend_data_in = byte_ff >= BC_W'(3);
                        pend_last_in = 1'b0;
                        case (byte_ff)
                           BC_W'(0): pend_cmd_in = cfg.page_cmd_base
                                                   | 8'(PAGE_W'(page_ff + cfg.page_rotate));
                           BC_W'(1): pend_cmd_in = cfg.col_low_cmd
                                                   | (cfg.flipped ? FLIP_COL_OFFSET : 8'd0);
                           BC_W'(2): pend_cmd_in = cfg.col_high_cmd;
                           default:  pend_cmd_in = 8'd0;
                        endcase
                        if (byte_ff >= BC_W'(COLUMNS + 2)) begin
                           byte_in = '0;
                           if (follow_page[PAGE_W]) begin
                              busy_in      = 1'b0;
                              page_in      = '0;
                              dirty_in     = '0;
                              pend_last_in = 1'b1;
                           end else begin
                              page_in = follow_page[PAGE_W-1:0];
                           end
                        end else begin
                           byte_in = byte_ff + BC_W'(1);
                        end
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW: begin
            ram_we    = 1'b1;
            ram_addr  = pix_addr_ff;
            ram_wdata = pix_colour_ff ? (ram_rdata | pix_bit_ff) : (ram_rdata & ~pix_bit_ff);
            state_in  = ST_IDLE;
         end
         ST_STEP_WAIT: begin
            rsp_valid_in   = 1'b1;
            rsp_byte_in    = pend_data_ff ? ram_rdata : pend_cmd_ff;
            rsp_is_data_in = pend_data_ff;
            rsp_last_in    = pend_last_ff;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pix_addr_ff    <= pix_addr_in;
      pix_bit_ff     <= pix_bit_in;
      pix_colour_ff  <= pix_colour_in;
      pend_cmd_ff    <= pend_cmd_in;
      pend_data_ff   <= pend_data_in;
      pend_last_ff   <= pend_last_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         busy_ff      <= 1'b0;
         page_ff      <= '0;
         byte_ff      <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         busy_ff      <= busy_in;
         page_ff      <= page_in;
         byte_ff      <= byte_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_out        = rsp_byte_ff;
   assign rsp_is_data         = rsp_is_data_ff;
   assign rsp_last_of_refresh = rsp_last_ff;

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_STEP_WAIT))
      else $error("output loaded without a pending step");

   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_STEP |-> !rsp_valid_ff || rsp_ready)
      else $error("step accepted while output register is held");

   a_sweep_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == ST_CLEAR) |-> $past(clr_ff) == ADDR_W'(DEPTH - 1))
      else $error("clear sweep left early");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_is_data_ff)
      else $error("final refresh byte is not a data byte");

endmodule
